@@ rtl/core/bmt_pkg.sv @@
// ----------------------------------------------------------------------------
// bmt_pkg
// Shared widths, command and kind codes, and the word that travels
// along the row of breakpoint cells.
// ----------------------------------------------------------------------------
`default_nettype none

package bmt_pkg;

    localparam int TABLE_SLOTS_DEF = 16;

    localparam int CMD_W   = 3;
    localparam int KIND_W  = 2;
    localparam int FN_W    = 16;
    localparam int OFF_W   = 16;
    localparam int CHAIN_W = 32;
    localparam int DEPTH_W = 16;
    localparam int ID_W    = 32;

    localparam logic [ID_W-1:0] MISS_CODE      = 32'hFFFF_FFFF;
    localparam logic [ID_W-1:0] LAST_USABLE_ID = 32'hFFFF_FFFE;

    localparam logic [CMD_W-1:0] CMD_ADD_LOCATION = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_STEPOVER = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ADD_FINISH   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ADD_ANYWHERE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE       = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CHECK        = 3'd5;

    localparam logic [KIND_W-1:0] KIND_LOCATION = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STEPOVER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FINISH   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ANYWHERE = 2'd3;

    // word handed from cell to cell, with the running result
    typedef struct packed {
        logic               valid;
        logic [CMD_W-1:0]   cmd;
        logic [FN_W-1:0]    function_id;
        logic [OFF_W-1:0]   code_offset;
        logic               once_flag;
        logic [CHAIN_W-1:0] chain_number;
        logic [DEPTH_W-1:0] depth_value;
        logic [ID_W-1:0]    ident;      // new id on add, id to drop on remove
        logic               exhausted;  // no identifiers left
        logic               placed;     // add stored by an earlier cell
        logic               hit;
        logic [ID_W-1:0]    best;
    } token_t;

endpackage

`default_nettype wire

@@ rtl/core/bmt_if.sv @@
// ----------------------------------------------------------------------------
// bmt_if
// Request and response channels of the breakpoint match table.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [15:0] function_id;
    logic [15:0] code_offset;
    logic        once_flag;
    logic [31:0] chain_number;
    logic [15:0] depth_value;
    logic [31:0] bp_id;

    modport source (
        output valid, cmd, function_id, code_offset, once_flag,
               chain_number, depth_value, bp_id,
        input  ready
    );
    modport sink (
        input  valid, cmd, function_id, code_offset, once_flag,
               chain_number, depth_value, bp_id,
        output ready
    );
endinterface

interface bmt_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [31:0] result_id;
    logic        table_full;

    modport source (
        output valid, hit, result_id, table_full,
        input  ready
    );
    modport sink (
        input  valid, hit, result_id, table_full,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/bmt_cell.sv @@
// ----------------------------------------------------------------------------
// bmt_cell
// One breakpoint slot. Takes the word from its left neighbour, applies
// add, remove or check to its own entry and passes the word on.
// ----------------------------------------------------------------------------
`default_nettype none

module bmt_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  bmt_pkg::token_t tok_in,
    output bmt_pkg::token_t tok_out
);
    import bmt_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic [KIND_W-1:0]  kind_reg;
    logic               once_reg;
    logic [ID_W-1:0]    ident_reg;
    logic [FN_W-1:0]    function_reg;
    logic [OFF_W-1:0]   offset_reg;
    logic [CHAIN_W-1:0] chain_reg;
    logic [DEPTH_W-1:0] depth_reg;

    token_t tok_reg;
    token_t tok_next;
    logic   load;
    logic   match;
    logic   is_add;

    always_comb
    begin
        unique case (kind_reg)
            KIND_LOCATION:
                match = (function_reg == tok_in.function_id) &&
                        (offset_reg == tok_in.code_offset);
            KIND_STEPOVER:
                match = ((tok_in.chain_number == chain_reg) &&
                         (tok_in.depth_value <= depth_reg)) ||
                        (tok_in.chain_number < chain_reg);
            KIND_FINISH:
                match = ((tok_in.chain_number == chain_reg) &&
                         (tok_in.depth_value < depth_reg)) ||
                        (tok_in.chain_number < chain_reg);
            KIND_ANYWHERE:
                match = 1'b1;
        endcase
    end

    assign is_add = (tok_in.cmd <= CMD_ADD_ANYWHERE);

    always_comb
    begin
        tok_next   = tok_in;
        valid_next = valid_reg;
        load       = 1'b0;
        if (tok_in.valid)
        begin
            if (is_add)
            begin
                // first free slot along the row takes the entry
                if (!valid_reg && !tok_in.placed && !tok_in.exhausted)
                begin
                    load            = 1'b1;
                    valid_next      = 1'b1;
                    tok_next.placed = 1'b1;
                end
            end
            else if (tok_in.cmd == CMD_REMOVE)
            begin
                if (valid_reg && (ident_reg == tok_in.ident))
                begin
                    valid_next   = 1'b0;
                    tok_next.hit = 1'b1;
                end
            end
            else if (tok_in.cmd == CMD_CHECK)
            begin
                if (valid_reg && match)
                begin
                    if (!tok_in.hit || (ident_reg > tok_in.best))
                    begin
                        tok_next.best = ident_reg;
                    end
                    tok_next.hit = 1'b1;
                    if (once_reg)
                    begin
                        valid_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg     <= tok_in.cmd[KIND_W-1:0];
            once_reg     <= (tok_in.cmd == CMD_ADD_LOCATION) ? tok_in.once_flag : 1'b1;
            ident_reg    <= tok_in.ident;
            function_reg <= tok_in.function_id;
            offset_reg   <= tok_in.code_offset;
            chain_reg    <= tok_in.chain_number;
            depth_reg    <= tok_in.depth_value;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

@@ rtl/core/breakpoint_match_table.sv @@
// an accepted word is registered at launch, walks the row one slot per
// cycle, then its result passes the pending and output registers and
// is offered; one word is in the row of slot cells at a time, and a new
// word is taken only after the last result has moved to the output register
// reset: all slots empty, last identifier zero, no result pending
// ----------------------------------------------------------------------------
// breakpoint_match_table
// Debug breakpoint table built as a row of slot cells: add, remove and
// check words pass through every cell, the tail forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module breakpoint_match_table #(
    parameter int TABLE_SLOTS = bmt_pkg::TABLE_SLOTS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    bmt_req_if.sink          req,
    bmt_rsp_if.source        rsp
);
    import bmt_pkg::*;

    token_t tok [TABLE_SLOTS+1];
    token_t launch_next;
    token_t tail;

    logic            accept;
    logic            move;
    logic            is_add;
    logic            busy_reg;
    logic            busy_next;
    logic [ID_W-1:0] last_ident_reg;
    logic [ID_W-1:0] last_ident_next;

    logic            pend_valid_reg;
    logic            pend_valid_next;
    logic            pend_hit_reg;
    logic            pend_hit_next;
    logic [ID_W-1:0] pend_id_reg;
    logic [ID_W-1:0] pend_id_next;
    logic            pend_full_reg;
    logic            pend_full_next;

    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_hit_reg;
    logic [ID_W-1:0] out_id_reg;
    logic            out_full_reg;

    assign accept = req.valid && req.ready;
    assign is_add = (req.cmd <= CMD_ADD_ANYWHERE);
    assign move   = pend_valid_reg && (!out_valid_reg || rsp.ready);
    assign tail   = tok[TABLE_SLOTS];

    always_comb
    begin
        launch_next              = '0;
        launch_next.valid        = accept;
        launch_next.cmd          = req.cmd;
        launch_next.function_id  = req.function_id;
        launch_next.code_offset  = req.code_offset;
        launch_next.once_flag    = req.once_flag;
        launch_next.chain_number = req.chain_number;
        launch_next.depth_value  = req.depth_value;
        launch_next.ident        = is_add ? (last_ident_reg + 32'd1) : req.bp_id;
        launch_next.exhausted    = (last_ident_reg >= LAST_USABLE_ID);
        launch_next.placed       = 1'b0;
        launch_next.hit          = 1'b0;
        launch_next.best         = MISS_CODE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok[0] <= '0;
        end
        else
        begin
            tok[0] <= launch_next;
        end
    end

    for (genvar k = 0; k < TABLE_SLOTS; k++)
    begin : g_cell
        bmt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok[k]),
            .tok_out (tok[k+1])
        );
    end

    // result of the word leaving the last cell
    always_comb
    begin
        last_ident_next = last_ident_reg;
        pend_hit_next   = pend_hit_reg;
        pend_id_next    = pend_id_reg;
        pend_full_next  = pend_full_reg;
        if (tail.valid)
        begin
            pend_hit_next  = 1'b0;
            pend_id_next   = '0;
            pend_full_next = 1'b0;
            if (tail.cmd <= CMD_ADD_ANYWHERE)
            begin
                if (tail.placed)
                begin
                    pend_id_next    = tail.ident;
                    last_ident_next = tail.ident;
                end
                else
                begin
                    pend_id_next   = MISS_CODE;
                    pend_full_next = 1'b1;
                end
            end
            else if (tail.cmd == CMD_REMOVE)
            begin
                pend_hit_next = tail.hit;
            end
            else if (tail.cmd == CMD_CHECK)
            begin
                pend_hit_next = tail.hit;
                pend_id_next  = tail.hit ? tail.best : MISS_CODE;
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (move)
        begin
            busy_next = 1'b0;
        end

        pend_valid_next = pend_valid_reg;
        if (tail.valid)
        begin
            pend_valid_next = 1'b1;
        end
        else if (move)
        begin
            pend_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (move)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            last_ident_reg <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            last_ident_reg <= last_ident_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_hit_reg  <= pend_hit_next;
        pend_id_reg   <= pend_id_next;
        pend_full_reg <= pend_full_next;
        if (move)
        begin
            out_hit_reg  <= pend_hit_reg;
            out_id_reg   <= pend_id_reg;
            out_full_reg <= pend_full_reg;
        end
    end

    assign req.ready      = !busy_reg;
    assign rsp.valid      = out_valid_reg;
    assign rsp.hit        = out_hit_reg;
    assign rsp.result_id  = out_id_reg;
    assign rsp.table_full = out_full_reg;

endmodule

`default_nettype wire
